### rtl/core/binomial_coefficient_core_defines.svh
// ============================================================================
// Assertion macros for the binomial coefficient core
// Shared property forms, clocked on i_clk and disabled while i_rst_n is low.
// ============================================================================
`ifndef BINOMIAL_COEFFICIENT_CORE_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_CORE_DEFINES_SVH

// Same-cycle implication.
`define BC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bc_pkg.sv
// ============================================================================
// Binomial coefficient package
// Widths, payload structs and sequencer states for the n choose k core.
// ============================================================================
`default_nettype none

package bc_pkg;

    // Largest n that is computed; above it the result is flagged.
    localparam int MAX_N     = 20;

    localparam int N_W       = 6;                          // n_value / k_value field
    localparam int COEF_W    = 18;                         // coefficient field
    localparam int NI_W      = $clog2(MAX_N + 1);          // n within range
    localparam int M_W       = $clog2(MAX_N / 2 + 2);      // m = min(k, n-k), divisor
    localparam int PROD_W    = COEF_W + NI_W;              // acc * (n-m+i)
    localparam int DIV_BITS  = 2;                          // quotient bits per cycle
    localparam int DIV_W     = PROD_W + (PROD_W % DIV_BITS);
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [N_W-1:0] n_value;
        logic [N_W-1:0] k_value;
    } t_operands;

    typedef struct packed {
        logic [COEF_W-1:0] coefficient;
        logic              out_of_range;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV
    } t_state;

endpackage

`default_nettype wire

### rtl/core/binomial_coefficient_core.sv
// ============================================================================
// Binomial coefficient core
// Exact n choose k by the multiplicative formula on one shared
// multiply-then-divide unit driven by a small sequencer.
// ============================================================================
//
//  channel   | ports                        | transfer
//  ----------+------------------------------+-----------------------------------
//  operands  | start, busy, i_operands      | edge with start high, busy low
//  result    | o_strobe, o_result           | edge ending the o_strobe cycle
//
//  Sequence: with m = min(k, n-k), an item with n above MAX_N, k above n or
//  m = 0 gives its result in the cycle after the transfer. Otherwise each of
//  the m steps runs the multiply state, then the radix-4 divider iterations,
//  then folds the quotient back into the running coefficient.
//  Reset: synchronous, active low; clears the sequencer, divider count and
//  strobe. The receiver cannot stall: each result shows for one cycle only.
//
`default_nettype none

`include "binomial_coefficient_core_defines.svh"

module binomial_coefficient_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire bc_pkg::t_operands i_operands,
    output logic                   busy,
    output logic                   o_strobe,
    output bc_pkg::t_result        o_result
);

    bc_pkg::t_state r_state, n_state;

    logic [bc_pkg::COEF_W-1:0] r_acc, n_acc;     // running partial coefficient
    logic [bc_pkg::M_W-1:0]    r_i,   n_i;       // current step, also divisor
    logic [bc_pkg::M_W-1:0]    r_m,   n_m;       // number of steps
    logic [bc_pkg::NI_W-1:0]   r_base, n_base;   // n - m
    logic                      r_strobe, n_strobe;
    bc_pkg::t_result           r_result, n_result;

    logic                      w_accept;
    logic [bc_pkg::N_W-1:0]    w_nk;
    logic [bc_pkg::N_W-1:0]    w_m6;
    logic [bc_pkg::NI_W-1:0]   w_factor;
    logic [bc_pkg::PROD_W-1:0] w_prod;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [bc_pkg::DIV_W-1:0]  w_quo;

    assign w_accept = start && !busy;

    // Operand decode: m = min(k, n-k), valid only when k <= n.
    assign w_nk = i_operands.n_value - i_operands.k_value;
    assign w_m6 = (i_operands.k_value < w_nk) ? i_operands.k_value : w_nk;

    // Shared multiply: acc * (n - m + i); registered inside the divider.
    assign w_factor = r_base + bc_pkg::NI_W'(r_i);
    assign w_prod   = bc_pkg::PROD_W'(r_acc) * bc_pkg::PROD_W'(w_factor);

    bc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (bc_pkg::DIV_W'(w_prod)),
        .i_divisor  (r_i),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bc_pkg::ST_IDLE: begin
                // Trivial items finish here; the rest run the step loop.
                if (w_accept
                    && (i_operands.n_value <= bc_pkg::N_W'(bc_pkg::MAX_N))
                    && (i_operands.k_value <= i_operands.n_value)
                    && (w_m6 != '0)) begin
                    n_state = bc_pkg::ST_MUL;
                end
            end
            bc_pkg::ST_MUL: begin
                n_state = bc_pkg::ST_DIV;
            end
            bc_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = (r_i == r_m) ? bc_pkg::ST_IDLE : bc_pkg::ST_MUL;
                end
            end
            default: begin
                n_state = bc_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_acc       = r_acc;
        n_i         = r_i;
        n_m         = r_m;
        n_base      = r_base;
        n_strobe    = 1'b0;
        n_result    = r_result;
        w_div_start = 1'b0;
        unique case (r_state)
            bc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_acc  = bc_pkg::COEF_W'(1);
                    n_i    = bc_pkg::M_W'(1);
                    n_m    = bc_pkg::M_W'(w_m6);
                    n_base = bc_pkg::NI_W'(i_operands.n_value - w_m6);
                    if (i_operands.n_value > bc_pkg::N_W'(bc_pkg::MAX_N)) begin
                        // Out of range: flag it, drop the value.
                        n_strobe                 = 1'b1;
                        n_result.coefficient     = '0;
                        n_result.out_of_range    = 1'b1;
                    end else if (i_operands.k_value > i_operands.n_value) begin
                        n_strobe                 = 1'b1;
                        n_result.coefficient     = '0;
                        n_result.out_of_range    = 1'b0;
                    end else if (w_m6 == '0) begin
                        // k equal to 0 or to n.
                        n_strobe                 = 1'b1;
                        n_result.coefficient     = bc_pkg::COEF_W'(1);
                        n_result.out_of_range    = 1'b0;
                    end
                end
            end
            bc_pkg::ST_MUL: begin
                // Hand acc * (n-m+i) to the divider with i as divisor.
                w_div_start = 1'b1;
            end
            bc_pkg::ST_DIV: begin
                if (w_div_done) begin
                    // The quotient is exact: acc * (n-m+i) = i * C(n-m+i, i).
                    n_acc = bc_pkg::COEF_W'(w_quo);
                    n_i   = r_i + 1'b1;
                    if (r_i == r_m) begin
                        n_strobe              = 1'b1;
                        n_result.coefficient  = bc_pkg::COEF_W'(w_quo);
                        n_result.out_of_range = 1'b0;
                    end
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bc_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_i      <= n_i;
        r_m      <= n_m;
        r_base   <= n_base;
        r_result <= n_result;
    end

    assign busy     = (r_state != bc_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `BC_ASSERT_NXT(a_accept_progress, w_accept, busy || o_strobe, "transfer without progress")
    `BC_ASSERT_IMP(a_oor_zero, o_strobe && o_result.out_of_range, o_result.coefficient == '0, "flagged result not zero")
    `BC_ASSERT_IMP(a_done_in_div, w_div_done, r_state == bc_pkg::ST_DIV, "divider done outside divide state")
    `BC_ASSERT_IMP(a_step_bound, r_state == bc_pkg::ST_MUL, (r_i != '0) && (r_i <= r_m), "step index out of bounds")

endmodule

`default_nettype wire

### rtl/core/bc_divider.sv
// ============================================================================
// Iterative unsigned divider
// Restoring division, two quotient bits per cycle, narrow divisor.
// ============================================================================
`default_nettype none

module bc_divider (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bc_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [bc_pkg::M_W-1:0]     i_divisor,
    output logic                            o_done,
    output logic [bc_pkg::DIV_W-1:0]        o_quotient
);

    logic [bc_pkg::M_W-1:0]   r_rem, n_rem;
    logic [bc_pkg::DIV_W-1:0] r_quo, n_quo;
    logic [bc_pkg::M_W-1:0]   r_div;
    logic [bc_pkg::CNT_W-1:0] r_cnt;
    logic                     r_done;

    // Shift dividend bits out of the top, quotient bits in at the bottom.
    always_comb begin
        logic [bc_pkg::M_W:0] trial;
        logic                 qbit;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int s = 0; s < bc_pkg::DIV_BITS; s++) begin
            trial = {n_rem, n_quo[bc_pkg::DIV_W-1]};
            if (trial >= {1'b0, r_div}) begin
                qbit  = 1'b1;
                n_rem = bc_pkg::M_W'(trial - {1'b0, r_div});
            end else begin
                qbit  = 1'b0;
                n_rem = trial[bc_pkg::M_W-1:0];
            end
            n_quo = {n_quo[bc_pkg::DIV_W-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= bc_pkg::CNT_W'(bc_pkg::DIV_STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == bc_pkg::CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire
